@@ rtl/cwdf_pkg.sv @@
// cwdf_pkg: shared types, codes and constants of the cone weight density filter.
// Used by cwdf_ctrl, cwdf_dp and cone_weight_density_filter. No dependencies.
package cwdf_pkg;

    localparam int COORD_W  = 16;
    localparam int DENS_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int IDX_W    = 6;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam logic [FUNC_W-1:0] FUNC_SRC   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TGT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DENS  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_APPLY = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SUM_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_RDY  = 2'd2;

    localparam logic CFG_SRC_COUNT = 1'b0;
    localparam logic CFG_TGT_COUNT = 1'b1;

    localparam logic [DENS_W-1:0] DENS_ONE = 16'd32768;

    // Q2.14 radius, indexed by floor(sqrt(source count)).
    localparam logic [15:0] RADIUS_Q14 [17] = '{
        16'd24329, 16'd24329, 16'd12164, 16'd8110, 16'd6082, 16'd4866,
        16'd4055,  16'd3476,  16'd3041,  16'd2703, 16'd2433, 16'd2212,
        16'd2027,  16'd1871,  16'd1738,  16'd1622, 16'd1521
    };

    typedef struct packed {
        logic                load;
        logic                ld_radius;
        logic                clr_sum;
        logic                rd_pts;
        logic                sq;
        logic                sqrt_init;
        logic                sqrt_step;
        logic                acc_raw;
        logic                rd_raw;
        logic                div_init;
        logic                div_step;
        logic                wr_weight;
        logic                rd_apply;
        logic                mul;
        logic                acc_apply;
        logic                clr_acc;
        logic                emit;
        logic                emit_idx;
        logic                emit_acc;
        logic                emit_last;
        logic [STATUS_W-1:0] emit_status;
    } cwdf_cmd_t;

    typedef struct packed {
        logic step_done;
        logic sum_zero;
        logic out_busy;
    } cwdf_sts_t;

    // radius for a source count n (1..256)
    function automatic logic [15:0] radius_of(input logic [8:0] n);
        logic [4:0] d;
        d = '0;
        for (int i = 1; i <= 16; i++) begin
            if (9'(i * i) <= n) d = d + 5'd1;
        end
        return RADIUS_Q14[d];
    endfunction

endpackage

@@ rtl/cwdf_dp.sv @@
// cwdf_dp: point, density, raw and weight memories plus the shared arithmetic
// (squares, bit-serial sqrt, bit-serial divide, MAC) and the result register. Uses cwdf_pkg.
module cwdf_dp #(
    parameter int MAX_SOURCES = 64,
    parameter int MAX_TARGETS = 64,
    parameter int SRC_CW      = $clog2(MAX_SOURCES + 1),
    parameter int TGT_CW      = $clog2(MAX_TARGETS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cwdf_pkg::cwdf_cmd_t                 cmd,
    output cwdf_pkg::cwdf_sts_t                 sts,
    input  logic [SRC_CW-1:0]                   k_cnt,
    input  logic [TGT_CW-1:0]                   j_cnt,
    input  logic [SRC_CW-1:0]                   s_eff,
    input  logic [cwdf_pkg::FUNC_W-1:0]         func,
    input  logic [cwdf_pkg::IDX_W-1:0]          idx,
    input  logic signed [cwdf_pkg::COORD_W-1:0] coord_x,
    input  logic signed [cwdf_pkg::COORD_W-1:0] coord_y,
    input  logic [cwdf_pkg::DENS_W-1:0]         density_in,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cwdf_pkg::STATUS_W-1:0]       status,
    output logic [cwdf_pkg::IDX_W-1:0]          target_index,
    output logic [cwdf_pkg::DENS_W-1:0]         density_out,
    output logic                                last
);
    localparam int SRC_AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int TGT_AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int W_AW   = (MAX_SOURCES * MAX_TARGETS > 1) ?
                            $clog2(MAX_SOURCES * MAX_TARGETS) : 1;
    localparam int SUM_W  = 16 + SRC_CW;
    localparam int ACC_W  = 32 + SRC_CW;
    localparam int SQ_W   = 34;

    logic [15:0] src_x_mem [MAX_SOURCES];
    logic [15:0] src_y_mem [MAX_SOURCES];
    logic [15:0] tgt_x_mem [MAX_TARGETS];
    logic [15:0] tgt_y_mem [MAX_TARGETS];
    logic [15:0] dens_mem  [MAX_SOURCES];
    logic [15:0] raw_mem   [MAX_SOURCES];
    logic [15:0] w_mem     [MAX_SOURCES * MAX_TARGETS];

    logic [8:0]        idx_ext;
    logic              src_ok, tgt_ok;
    logic [SRC_AW-1:0] k_a;
    logic [TGT_AW-1:0] j_a;
    logic [W_AW-1:0]   w_addr;

    logic [15:0] sx_reg, sy_reg, tx_reg, ty_reg, raw_rd_reg, w_rd_reg, dens_rd_reg;
    logic [31:0] sqx_reg, sqy_reg, prod_reg;
    logic [SQ_W-1:0] sv_reg, sr_reg, sb_reg;
    logic [4:0]  step_reg;
    logic [15:0] radius_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W:0]   rem_reg;
    logic [31:0] dn_reg, q_reg;
    logic [ACC_W-1:0] acc_reg;
    logic m_tvalid_reg;

    logic signed [16:0] dx, dy;
    logic [15:0] ax, ay;
    logic [SQ_W-1:0] s_try;
    logic in_r;
    logic [15:0] raw;
    logic [SUM_W:0] rem_n;
    logic div_ge;
    logic [15:0] dens_sat, w_sat;
    logic [ACC_W:0] rnd;
    logic [ACC_W-16:0] rnd_hi;
    logic [15:0] dens_res;

    assign idx_ext = 9'(idx);
    assign src_ok  = idx_ext < 9'(MAX_SOURCES);
    assign tgt_ok  = idx_ext < 9'(MAX_TARGETS);
    assign k_a     = k_cnt[SRC_AW-1:0];
    assign j_a     = j_cnt[TGT_AW-1:0];
    assign w_addr  = W_AW'(int'(j_a) * MAX_SOURCES + int'(k_a));

    assign dens_sat = (density_in > cwdf_pkg::DENS_ONE) ? cwdf_pkg::DENS_ONE : density_in;

    // loads and point reads
    always_ff @(posedge aclk) begin
        if (cmd.load && func == cwdf_pkg::FUNC_SRC && src_ok) begin
            src_x_mem[idx_ext[SRC_AW-1:0]] <= coord_x;
            src_y_mem[idx_ext[SRC_AW-1:0]] <= coord_y;
        end
        if (cmd.rd_pts) begin
            sx_reg <= src_x_mem[k_a];
            sy_reg <= src_y_mem[k_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && func == cwdf_pkg::FUNC_TGT && tgt_ok) begin
            tgt_x_mem[idx_ext[TGT_AW-1:0]] <= coord_x;
            tgt_y_mem[idx_ext[TGT_AW-1:0]] <= coord_y;
        end
        if (cmd.rd_pts) begin
            tx_reg <= tgt_x_mem[j_a];
            ty_reg <= tgt_y_mem[j_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && func == cwdf_pkg::FUNC_DENS && src_ok) begin
            dens_mem[idx_ext[SRC_AW-1:0]] <= dens_sat;
        end
        if (cmd.rd_apply) begin
            dens_rd_reg <= dens_mem[k_a];
        end
    end

    // distance: abs differences, squares
    assign dx = {tx_reg[15], tx_reg} - {sx_reg[15], sx_reg};
    assign dy = {ty_reg[15], ty_reg} - {sy_reg[15], sy_reg};
    assign ax = dx[16] ? 16'(-dx) : dx[15:0];
    assign ay = dy[16] ? 16'(-dy) : dy[15:0];

    always_ff @(posedge aclk) begin
        if (cmd.sq) begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
        end
    end

    // restoring square root, one result bit per step, 17 steps
    assign s_try = sr_reg + sb_reg;

    // restoring divide, one quotient bit per step, 32 steps
    assign rem_n  = {rem_reg[SUM_W-1:0], dn_reg[31]};
    assign div_ge = rem_n >= {1'b0, sum_reg};

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            sv_reg   <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
            sr_reg   <= '0;
            sb_reg   <= SQ_W'(1) << 32;
            step_reg <= '0;
        end else if (cmd.sqrt_step) begin
            if (sv_reg >= s_try) begin
                sv_reg <= sv_reg - s_try;
                sr_reg <= (sr_reg >> 1) + sb_reg;
            end else begin
                sr_reg <= sr_reg >> 1;
            end
            sb_reg   <= sb_reg >> 2;
            step_reg <= step_reg + 5'd1;
        end else if (cmd.div_init) begin
            dn_reg   <= {raw_rd_reg, 16'b0} + 32'(sum_reg >> 1);
            rem_reg  <= '0;
            q_reg    <= '0;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? (rem_n - {1'b0, sum_reg}) : rem_n;
            dn_reg   <= dn_reg << 1;
            q_reg    <= {q_reg[30:0], div_ge};
            step_reg <= step_reg + 5'd1;
        end
    end

    assign sts.step_done = (cmd.sqrt_step && step_reg == 5'd16) ||
                           (cmd.div_step && step_reg == 5'd31);

    // cone weight and row sum
    assign in_r = {1'b0, sr_reg[16:0]} < {2'b0, radius_reg};
    assign raw  = in_r ? (radius_reg - sr_reg[15:0]) : 16'd0;

    always_ff @(posedge aclk) begin
        if (cmd.ld_radius) begin
            radius_reg <= cwdf_pkg::radius_of(9'(s_eff));
        end
        if (cmd.clr_sum) begin
            sum_reg <= '0;
        end else if (cmd.acc_raw) begin
            sum_reg <= sum_reg + SUM_W'(raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_raw) begin
            raw_mem[k_a] <= raw;
        end
        if (cmd.rd_raw) begin
            raw_rd_reg <= raw_mem[k_a];
        end
    end

    assign sts.sum_zero = (sum_reg == '0);

    assign w_sat = (q_reg > 32'd65535) ? 16'hFFFF : q_reg[15:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_weight) begin
            w_mem[w_addr] <= w_sat;
        end
        if (cmd.rd_apply) begin
            w_rd_reg <= w_mem[w_addr];
        end
    end

    // weighted density sum
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= w_rd_reg * dens_rd_reg;
        end
        if (cmd.clr_acc) begin
            acc_reg <= '0;
        end else if (cmd.acc_apply) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign rnd      = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(32768);
    assign rnd_hi   = rnd[ACC_W:16];
    assign dens_res = (rnd_hi > (ACC_W - 15)'(32768)) ? cwdf_pkg::DENS_ONE : rnd_hi[15:0];

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status       <= cmd.emit_status;
            target_index <= cmd.emit_idx ? 6'(9'(j_cnt)) : '0;
            density_out  <= cmd.emit_acc ? dens_res : '0;
            last         <= cmd.emit_last;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign sts.out_busy = m_tvalid_reg;

endmodule

@@ rtl/cwdf_ctrl.sv @@
// cwdf_ctrl: sequencer for loads, weight compute and apply; holds the count
// registers, the weights-ready flag and the target/source counters. Uses cwdf_pkg.
module cwdf_ctrl #(
    parameter int MAX_SOURCES = 64,
    parameter int MAX_TARGETS = 64,
    parameter int SRC_CW      = $clog2(MAX_SOURCES + 1),
    parameter int TGT_CW      = $clog2(MAX_TARGETS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cwdf_pkg::FUNC_W-1:0]  func,
    input  logic [cwdf_pkg::IDX_W-1:0]   idx,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [cwdf_pkg::CFG_W-1:0]   cfg_data,
    output cwdf_pkg::cwdf_cmd_t          cmd,
    input  cwdf_pkg::cwdf_sts_t          sts,
    output logic [SRC_CW-1:0]            k_cnt,
    output logic [TGT_CW-1:0]            j_cnt,
    output logic [SRC_CW-1:0]            s_eff
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_C_RD   = 4'd1;
    localparam logic [3:0] ST_C_SQ   = 4'd2;
    localparam logic [3:0] ST_C_ADD  = 4'd3;
    localparam logic [3:0] ST_C_SQRT = 4'd4;
    localparam logic [3:0] ST_C_ACC  = 4'd5;
    localparam logic [3:0] ST_C_CHK  = 4'd6;
    localparam logic [3:0] ST_D_RD   = 4'd7;
    localparam logic [3:0] ST_D_INIT = 4'd8;
    localparam logic [3:0] ST_D_DIV  = 4'd9;
    localparam logic [3:0] ST_D_WR   = 4'd10;
    localparam logic [3:0] ST_A_RD   = 4'd11;
    localparam logic [3:0] ST_A_MUL  = 4'd12;
    localparam logic [3:0] ST_A_ACC  = 4'd13;
    localparam logic [3:0] ST_A_OUT  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [SRC_CW-1:0] k_reg, k_next;
    logic [TGT_CW-1:0] j_reg, j_next;
    logic [cwdf_pkg::CFG_W-1:0] src_cnt_reg, tgt_cnt_reg;
    logic wready_reg, wready_next;
    logic [TGT_CW-1:0] t_eff;
    logic s_acc, cfg_acc, last_k, last_j, pt_load;

    assign s_eff = (src_cnt_reg == '0) ? SRC_CW'(1) :
                   (int'(src_cnt_reg) > MAX_SOURCES) ? SRC_CW'(MAX_SOURCES) :
                   SRC_CW'(src_cnt_reg);
    assign t_eff = (tgt_cnt_reg == '0) ? TGT_CW'(1) :
                   (int'(tgt_cnt_reg) > MAX_TARGETS) ? TGT_CW'(MAX_TARGETS) :
                   TGT_CW'(tgt_cnt_reg);

    assign s_tready  = (state_reg == ST_IDLE) && !sts.out_busy;
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign last_k    = (k_reg == s_eff - SRC_CW'(1));
    assign last_j    = (j_reg == t_eff - TGT_CW'(1));
    assign pt_load   = ((func == cwdf_pkg::FUNC_SRC) && (int'(idx) < MAX_SOURCES)) ||
                       ((func == cwdf_pkg::FUNC_TGT) && (int'(idx) < MAX_TARGETS));

    assign k_cnt = k_reg;
    assign j_cnt = j_reg;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        wready_next = wready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd.load = 1'b1;
                    case (func)
                        cwdf_pkg::FUNC_SRC, cwdf_pkg::FUNC_TGT: begin
                            if (pt_load) wready_next = 1'b0;
                        end
                        cwdf_pkg::FUNC_COMP: begin
                            cmd.ld_radius = 1'b1;
                            cmd.clr_sum   = 1'b1;
                            k_next        = '0;
                            j_next        = '0;
                            state_next    = ST_C_RD;
                        end
                        cwdf_pkg::FUNC_APPLY: begin
                            k_next = '0;
                            j_next = '0;
                            if (wready_reg) begin
                                state_next = ST_A_RD;
                            end else begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = cwdf_pkg::STATUS_NOT_RDY;
                                cmd.emit_last   = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_C_RD: begin
                cmd.rd_pts = 1'b1;
                state_next = ST_C_SQ;
            end
            ST_C_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_C_ADD;
            end
            ST_C_ADD: begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_C_SQRT;
            end
            ST_C_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.step_done) state_next = ST_C_ACC;
            end
            ST_C_ACC: begin
                cmd.acc_raw = 1'b1;
                if (last_k) begin
                    state_next = ST_C_CHK;
                end else begin
                    k_next     = k_reg + SRC_CW'(1);
                    state_next = ST_C_RD;
                end
            end
            ST_C_CHK: begin
                k_next = '0;
                if (sts.sum_zero) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_idx    = 1'b1;
                    cmd.emit_status = cwdf_pkg::STATUS_SUM_ZERO;
                    cmd.emit_last   = 1'b1;
                    wready_next     = 1'b0;
                    state_next      = ST_IDLE;
                end else begin
                    state_next = ST_D_RD;
                end
            end
            ST_D_RD: begin
                cmd.rd_raw = 1'b1;
                state_next = ST_D_INIT;
            end
            ST_D_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_D_DIV;
            end
            ST_D_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.step_done) state_next = ST_D_WR;
            end
            ST_D_WR: begin
                cmd.wr_weight = 1'b1;
                if (!last_k) begin
                    k_next     = k_reg + SRC_CW'(1);
                    state_next = ST_D_RD;
                end else if (!last_j) begin
                    k_next      = '0;
                    j_next      = j_reg + TGT_CW'(1);
                    cmd.clr_sum = 1'b1;
                    state_next  = ST_C_RD;
                end else begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = cwdf_pkg::STATUS_OK;
                    cmd.emit_last   = 1'b1;
                    wready_next     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_A_RD: begin
                cmd.rd_apply = 1'b1;
                cmd.clr_acc  = (k_reg == '0);
                state_next   = ST_A_MUL;
            end
            ST_A_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_A_ACC;
            end
            ST_A_ACC: begin
                cmd.acc_apply = 1'b1;
                if (last_k) begin
                    state_next = ST_A_OUT;
                end else begin
                    k_next     = k_reg + SRC_CW'(1);
                    state_next = ST_A_RD;
                end
            end
            ST_A_OUT: begin
                if (!sts.out_busy) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_idx    = 1'b1;
                    cmd.emit_acc    = 1'b1;
                    cmd.emit_status = cwdf_pkg::STATUS_OK;
                    cmd.emit_last   = last_j;
                    k_next          = '0;
                    if (last_j) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + TGT_CW'(1);
                        state_next = ST_A_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_acc) wready_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            j_reg       <= '0;
            wready_reg  <= 1'b0;
            src_cnt_reg <= 7'd64;
            tgt_cnt_reg <= 7'd64;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            wready_reg <= wready_next;
            if (cfg_acc && cfg_index == cwdf_pkg::CFG_SRC_COUNT) src_cnt_reg <= cfg_data;
            if (cfg_acc && cfg_index == cwdf_pkg::CFG_TGT_COUNT) tgt_cnt_reg <= cfg_data;
        end
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !sts.out_busy)
        else $error("result issued while output register full");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> k_reg < s_eff)
        else $error("source counter beyond source count");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> !wready_reg)
        else $error("weights still marked ready after count write");

endmodule

@@ rtl/cone_weight_density_filter.sv @@
// Cone weight density filter for one 2x2 cell.
// Channels: s_ (input items), m_ (result items), cfg_ (count register writes).
// s_tuser carries func: 0 load source, 1 load target, 3 load density,
// 2 compute weights, 4 apply. Loads give no result.
// Compute walks every target/source pair: a distance per pair
// (17-step serial square root), then the normalizing 32-step serial
// divide per pair, plus one row check per target; a target with a zero
// row sum ends it early. One result at the end.
// Apply does one weight memory read and one MAC per source, then the result load, per
// target, giving T results in target order (tlast on the final one) or one not-ready result.
// The sequencer takes one item at a time: s_tready is high only while idle and
// with the result register empty. A stalled m_tready holds the result register
// and the sequencer waits on it before issuing the next result.
// Reset clears the control state, sets both counts to 64 and marks weights not
// ready; point, density and weight memories are not cleared.
// Writes to cfg are always accepted and clear the weights-ready flag.
// Depends on cwdf_pkg, cwdf_ctrl, cwdf_dp.
module cone_weight_density_filter #(
    parameter int MAX_SOURCES = 64,
    parameter int MAX_TARGETS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // point_index[5:0], coord_x[21:6], coord_y[37:22],
                                   // density_in[53:38], zero pad
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // target_index[5:0], density_out[21:6], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    localparam int SRC_CW = $clog2(MAX_SOURCES + 1);
    localparam int TGT_CW = $clog2(MAX_TARGETS + 1);

    cwdf_pkg::cwdf_cmd_t cmd;
    cwdf_pkg::cwdf_sts_t sts;
    logic [SRC_CW-1:0] k_cnt, s_eff;
    logic [TGT_CW-1:0] j_cnt;
    logic [5:0]  target_index;
    logic [15:0] density_out;

    cwdf_ctrl #(
        .MAX_SOURCES(MAX_SOURCES),
        .MAX_TARGETS(MAX_TARGETS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .idx       (s_tdata[5:0]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .k_cnt     (k_cnt),
        .j_cnt     (j_cnt),
        .s_eff     (s_eff)
    );

    cwdf_dp #(
        .MAX_SOURCES(MAX_SOURCES),
        .MAX_TARGETS(MAX_TARGETS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .k_cnt        (k_cnt),
        .j_cnt        (j_cnt),
        .s_eff        (s_eff),
        .func         (s_tuser),
        .idx          (s_tdata[5:0]),
        .coord_x      (s_tdata[21:6]),
        .coord_y      (s_tdata[37:22]),
        .density_in   (s_tdata[53:38]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .status       (m_tuser),
        .target_index (target_index),
        .density_out  (density_out),
        .last         (m_tlast)
    );

    assign m_tdata = {2'b00, density_out, target_index};

endmodule

@@ sim/cone_weight_density_filter_tb.sv @@
// Self-checking bench for cone_weight_density_filter: loads, compute, apply and count writes.
// Expected results come from a scoreboard class that models the filter state.
// Depends on cwdf_pkg and the RTL of cone_weight_density_filter.
module cone_weight_density_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 40;
    localparam int ITEM_GOAL   = 420;

    typedef struct {
        logic [cwdf_pkg::STATUS_W-1:0] status;
        logic [cwdf_pkg::IDX_W-1:0]    tgt;
        logic [cwdf_pkg::DENS_W-1:0]   dens;
        logic                          last;
    } filt_result_t;

    class filter_scoreboard;
        logic signed [cwdf_pkg::COORD_W-1:0] sx [64];
        logic signed [cwdf_pkg::COORD_W-1:0] sy [64];
        logic signed [cwdf_pkg::COORD_W-1:0] tx [64];
        logic signed [cwdf_pkg::COORD_W-1:0] ty [64];
        logic [cwdf_pkg::DENS_W-1:0]         sd [64];
        logic [cwdf_pkg::WEIGHT_W-1:0]       wt [4096];
        bit                                  wready;
        logic [cwdf_pkg::CFG_W-1:0]          scount;
        logic [cwdf_pkg::CFG_W-1:0]          tcount;
        filt_result_t                        pending_q [$];
        int                                  errors;

        function new();
            wready = 0;
            scount = 7'd64;
            tcount = 7'd64;
            errors = 0;
        endfunction

        function int eff(logic [cwdf_pkg::CFG_W-1:0] c);
            if (c == 0) return 1;
            return (c > 64) ? 64 : int'(c);
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void push(logic [cwdf_pkg::STATUS_W-1:0] st, int t,
                           logic [cwdf_pkg::DENS_W-1:0] d, bit l);
            filt_result_t e;
            e.status = st;
            e.tgt = cwdf_pkg::IDX_W'(t);
            e.dens = d;
            e.last = l;
            pending_q.push_back(e);
        endfunction

        function void set_count(logic idx, logic [cwdf_pkg::CFG_W-1:0] v);
            if (idx == cwdf_pkg::CFG_SRC_COUNT) scount = v;
            else tcount = v;
            wready = 0;
        endfunction

        function void note_item(logic [cwdf_pkg::FUNC_W-1:0] fn,
                                logic [cwdf_pkg::IDX_W-1:0] idx,
                                logic [cwdf_pkg::COORD_W-1:0] x,
                                logic [cwdf_pkg::COORD_W-1:0] y,
                                logic [cwdf_pkg::DENS_W-1:0] d);
            int ns, nt, dq;
            longint unsigned radius, span_q, sum, w, acc, r;
            longint signed dx, dy;
            longint unsigned raw [64];
            ns = eff(scount);
            nt = eff(tcount);
            case (fn)
                cwdf_pkg::FUNC_SRC: begin
                    sx[idx] = x; sy[idx] = y; wready = 0;
                end
                cwdf_pkg::FUNC_TGT: begin
                    tx[idx] = x; ty[idx] = y; wready = 0;
                end
                cwdf_pkg::FUNC_DENS: sd[idx] = (d > cwdf_pkg::DENS_ONE) ? cwdf_pkg::DENS_ONE : d;
                cwdf_pkg::FUNC_COMP: begin
                    dq = 0;
                    while ((dq + 1) * (dq + 1) <= ns && dq < 16) dq++;
                    radius = cwdf_pkg::RADIUS_Q14[dq];
                    for (int j = 0; j < nt; j++) begin
                        sum = 0;
                        for (int k = 0; k < ns; k++) begin
                            dx = longint'(tx[j]) - longint'(sx[k]);
                            dy = longint'(ty[j]) - longint'(sy[k]);
                            if (dx < 0) dx = -dx;
                            if (dy < 0) dy = -dy;
                            span_q = root_floor(dx * dx + dy * dy);
                            raw[k] = (span_q < radius) ? radius - span_q : 0;
                            sum += raw[k];
                        end
                        if (sum == 0) begin
                            for (int k = 0; k < ns; k++) wt[j * 64 + k] = '0;
                            wready = 0;
                            push(cwdf_pkg::STATUS_SUM_ZERO, j, '0, 1);
                            return;
                        end
                        for (int k = 0; k < ns; k++) begin
                            w = ((raw[k] << 16) + sum / 2) / sum;
                            wt[j * 64 + k] = (w > 65535) ? 16'hFFFF : cwdf_pkg::WEIGHT_W'(w);
                        end
                    end
                    wready = 1;
                    push(cwdf_pkg::STATUS_OK, 0, '0, 1);
                end
                cwdf_pkg::FUNC_APPLY: begin
                    if (!wready) begin
                        push(cwdf_pkg::STATUS_NOT_RDY, 0, '0, 1);
                        return;
                    end
                    for (int j = 0; j < nt; j++) begin
                        acc = 0;
                        for (int k = 0; k < ns; k++)
                            acc += longint'(wt[j * 64 + k]) * longint'(sd[k]);
                        r = (acc + 32768) >> 16;
                        if (r > 32768) r = 32768;
                        push(cwdf_pkg::STATUS_OK, j, cwdf_pkg::DENS_W'(r), j + 1 == nt);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check(logic [cwdf_pkg::STATUS_W-1:0] st, logic [cwdf_pkg::IDX_W-1:0] t,
                            logic [cwdf_pkg::DENS_W-1:0] d, logic l);
            filt_result_t e;
            if (pending_q.size() == 0) begin
                $error("result item with nothing expected: status %0d target %0d", st, t);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status) begin
                $error("status expected %0d actual %0d", e.status, st); errors++;
            end
            if (t !== e.tgt) begin
                $error("target_index expected %0d actual %0d", e.tgt, t); errors++;
            end
            if (d !== e.dens) begin
                $error("density_out expected %0d actual %0d", e.dens, d); errors++;
            end
            if (l !== e.last) begin
                $error("last expected %0d actual %0d", e.last, l); errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    filter_scoreboard sb;
    int  sent;
    int  cycles;
    bit  calm;    // no gaps or stalls while set
    bit  started;

    cone_weight_density_filter u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("cone_weight_density_filter_tb: errors");
            $finish;
        end
    end

    // result side: random stall before each item
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (started);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check(m_tuser, m_tdata[5:0], m_tdata[21:6], m_tlast);
            @(negedge aclk);
        end
    end

    task automatic send_item(logic [cwdf_pkg::FUNC_W-1:0] fn, logic [cwdf_pkg::IDX_W-1:0] idx,
                             logic [cwdf_pkg::COORD_W-1:0] x, logic [cwdf_pkg::COORD_W-1:0] y,
                             logic [cwdf_pkg::DENS_W-1:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {2'b00, d, y, x, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(fn, idx, x, y, d);
        sent++;
        @(negedge aclk);
    endtask

    task automatic write_count(logic idx, logic [cwdf_pkg::CFG_W-1:0] v);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_count(idx, v);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [cwdf_pkg::COORD_W-1:0] in_cell();
        return cwdf_pkg::COORD_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic set_counts(logic [cwdf_pkg::CFG_W-1:0] s, logic [cwdf_pkg::CFG_W-1:0] t);
        write_count(cwdf_pkg::CFG_SRC_COUNT, s);
        write_count(cwdf_pkg::CFG_TGT_COUNT, t);
    endtask

    initial begin
        int ns, nt, n, hi;
        logic [cwdf_pkg::COORD_W-1:0] bx, by;
        logic [2:0] pick;
        sb = new();
        sent = 0;
        cycles = 0;
        calm = 0;
        started = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        started = 1;

        // apply with no weights, then the unused func codes
        send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
        send_item(3'd5, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(3'd6, '0, '0, '0, '0);
        send_item(3'd7, 6'd21, 16'h5555, 16'hAAAA, 16'h5555);

        // every point and density entry written once so no read hits an unwritten entry
        for (int i = 0; i < 64; i++) begin
            send_item(cwdf_pkg::FUNC_SRC, cwdf_pkg::IDX_W'(i), in_cell(), in_cell(), '0);
            send_item(cwdf_pkg::FUNC_TGT, cwdf_pkg::IDX_W'(i), in_cell(), in_cell(), '0);
            case (i)
                0: n = 0;
                1: n = 32768;
                2: n = 32769;
                3: n = 65535;
                default: n = $urandom_range(0, 32768);
            endcase
            send_item(cwdf_pkg::FUNC_DENS, cwdf_pkg::IDX_W'(i), '0, '0, cwdf_pkg::DENS_W'(n));
        end
        drain();

        // opposite corners: empty row, then apply not ready; then coincident points and count extremes
        set_counts(7'd0, 7'd0);
        send_item(cwdf_pkg::FUNC_SRC, '0, 16'h8000, 16'h8000, '0);
        send_item(cwdf_pkg::FUNC_TGT, '0, 16'h7FFF, 16'h7FFF, '0);
        send_item(cwdf_pkg::FUNC_COMP, '0, '0, '0, '0);
        send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
        send_item(cwdf_pkg::FUNC_TGT, '0, 16'h7FFF, 16'h8000, '0);
        send_item(cwdf_pkg::FUNC_SRC, '0, 16'h7FFF, 16'h8000, '0);
        send_item(cwdf_pkg::FUNC_COMP, '0, '0, '0, '0);
        send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
        drain();
        set_counts(7'd127, 7'd1);
        send_item(cwdf_pkg::FUNC_COMP, '0, '0, '0, '0);
        send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
        drain();
        set_counts(7'd1, 7'd127);
        send_item(cwdf_pkg::FUNC_COMP, '0, '0, '0, '0);
        send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
        drain();

        while (sent < ITEM_GOAL) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin ns = 64; nt = $urandom_range(1, 2); end
                1: begin ns = $urandom_range(9, 20); nt = $urandom_range(1, 3); end
                default: begin ns = $urandom_range(1, 8); nt = $urandom_range(1, 8); end
            endcase
            set_counts(cwdf_pkg::CFG_W'(ns == 64 && $urandom_range(0, 1) ? 127 : ns),
                       cwdf_pkg::CFG_W'(nt));
            hi = (ns > nt) ? ns : nt;
            // sources and targets scattered around one spot so rows usually hit
            bx = in_cell();
            by = in_cell();
            n = $urandom_range(2, 10);
            for (int i = 0; i < n; i++) begin
                pick = 3'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0) begin
                    send_item(3'($urandom_range(0, 7)), 6'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
                end else if (pick == 3) begin
                    send_item(cwdf_pkg::FUNC_DENS, cwdf_pkg::IDX_W'($urandom_range(0, hi - 1)),
                              '0, '0, cwdf_pkg::DENS_W'($urandom_range(0, 36000)));
                end else begin
                    send_item(pick[0] ? cwdf_pkg::FUNC_TGT : cwdf_pkg::FUNC_SRC,
                              cwdf_pkg::IDX_W'($urandom_range(0, hi - 1)),
                              bx + cwdf_pkg::COORD_W'(int'($urandom_range(0, 8000)) - 4000),
                              by + cwdf_pkg::COORD_W'(int'($urandom_range(0, 8000)) - 4000),
                              '0);
                end
            end
            if ($urandom_range(0, 5) != 0) send_item(cwdf_pkg::FUNC_COMP, '0, '0, '0, '0);
            send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
            if ($urandom_range(0, 2) == 0) begin
                send_item(cwdf_pkg::FUNC_DENS, cwdf_pkg::IDX_W'($urandom_range(0, hi - 1)),
                          '0, '0, cwdf_pkg::DENS_W'($urandom));
                send_item(cwdf_pkg::FUNC_APPLY, '0, '0, '0, '0);
            end
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("cone_weight_density_filter_tb: clean");
        end else begin
            $display("cone_weight_density_filter_tb: errors");
        end
        $finish;
    end

endmodule
